FILE: hdl/rswm_pkg.sv
// Package for the running latency statistics block.
// Holds widths and the struct passed from the front part to the back part.
package rswm_pkg;

  localparam int unsigned LagW   = 32;
  localparam int unsigned CountW = 40;
  localparam int unsigned SumW   = 64;
  localparam int unsigned OutW   = CountW + 4 * LagW;

  // Totals handed from the front part to the back part for one sample.
  typedef struct packed {
    logic signed [LagW-1:0]   lag;
    logic [CountW-1:0]        count;
    logic signed [LagW-1:0]   lo;
    logic signed [LagW-1:0]   hi;
    logic signed [SumW-1:0]   sum;
  } rswm_item_t;

endpackage

FILE: hdl/rswm_front.sv
// Front part: accepts samples and updates count, minimum, maximum and sum.
// Depends on rswm_pkg.
module rswm_front import rswm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [LagW-1:0]   in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output rswm_item_t        q_item_o
);

  logic [CountW-1:0]      count_q;
  logic signed [LagW-1:0] lo_q, hi_q;
  logic signed [SumW-1:0] sum_q;
  logic                   full_q;
  rswm_item_t             item_q;

  logic signed [LagW-1:0] x;
  logic signed [SumW-1:0] xs, add;
  logic                   first, take;
  rswm_item_t             item_d;

  assign x     = $signed(in_data_i);
  assign xs    = SumW'(x);
  assign add   = sum_q + xs;
  assign first = (count_q == '0);
  assign in_ready_o = !full_q;
  assign take  = in_valid_i && in_ready_o;

  // Saturating totals for the new sample.
  always_comb begin
    item_d.lag   = x;
    item_d.count = (count_q == {CountW{1'b1}}) ? count_q : count_q + 1'b1;
    item_d.lo    = (first || x < lo_q) ? x : lo_q;
    item_d.hi    = (first || x > hi_q) ? x : hi_q;
    if (!xs[SumW-1] && !sum_q[SumW-1] && add[SumW-1]) begin
      item_d.sum = {1'b0, {(SumW-1){1'b1}}};
    end else if (xs[SumW-1] && sum_q[SumW-1] && !add[SumW-1]) begin
      item_d.sum = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      item_d.sum = add;
    end
  end

  // One-entry queue toward the back part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      sum_q   <= '0;
      full_q  <= 1'b0;
    end else begin
      if (q_ready_i && full_q) full_q <= 1'b0;
      if (take) begin
        count_q <= item_d.count;
        lo_q    <= item_d.lo;
        hi_q    <= item_d.hi;
        sum_q   <= item_d.sum;
        full_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= item_d;
  end

  assign q_valid_o = full_q;
  assign q_item_o  = item_q;

endmodule

FILE: hdl/rswm_div.sv
// Restoring divider: signed 64-bit sum by unsigned 40-bit count, one bit a cycle.
// Depends on rswm_pkg; result clamps to the signed 32-bit range.
module rswm_div import rswm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] num_i,
  input  logic [CountW-1:0]      den_i,
  output logic                   done_o,
  output logic [LagW-1:0]        quo_o
);

  logic [SumW-1:0]   n_q, q_q;
  logic [CountW:0]   r_q;
  logic [CountW-1:0] d_q;
  logic              neg_q, busy_q, done_q;
  logic [6:0]        cnt_q;
  logic [CountW:0]   r_sh;
  logic [CountW+1:0] diff;
  logic [SumW-1:0]   qs;

  assign r_sh = {r_q[CountW-1:0], n_q[SumW-1]};
  assign diff = {1'b0, r_sh} - {2'b0, d_q};

  // Shift, trial subtract and restore. Done stays high until the next start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= 7'(SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[SumW-1];
      n_q   <= num_i[SumW-1] ? SumW'(-num_i) : num_i;
      d_q   <= den_i;
      r_q   <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[SumW-2:0], 1'b0};
      if (!diff[CountW+1]) begin
        r_q <= diff[CountW:0];
        q_q <= {q_q[SumW-2:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[SumW-2:0], 1'b0};
      end
    end
  end

  // Sign and clamp; the magnitude of the minimum sum fits as unsigned.
  always_comb begin
    qs = neg_q ? SumW'(-q_q) : q_q;
    if (!neg_q && q_q > SumW'(32'h7FFF_FFFF)) begin
      quo_o = 32'h7FFF_FFFF;
    end else if (neg_q && q_q > SumW'(33'h8000_0000)) begin
      quo_o = 32'h8000_0000;
    end else begin
      quo_o = qs[LagW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

FILE: hdl/rswm_back.sv
// Back part: window ring and sorted window held in memories, the median lookup
// and the mean divider. Depends on rswm_pkg and rswm_div.
module rswm_back import rswm_pkg::*; #(
  parameter int unsigned WindowDepth = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  rswm_item_t        q_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OutW-1:0]   out_data_o
);

  localparam int unsigned AW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned FW = $clog2(WindowDepth + 1);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRdOld = 4'd1;
  localparam logic [3:0] StFind  = 4'd2;
  localparam logic [3:0] StRem   = 4'd3;
  localparam logic [3:0] StIns   = 4'd4;
  localparam logic [3:0] StPut   = 4'd5;
  localparam logic [3:0] StMed   = 4'd6;
  localparam logic [3:0] StWait  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StRdW   = 4'd9;
  localparam logic [3:0] StShift = 4'd10;
  localparam logic [3:0] StTrim  = 4'd11;
  localparam logic [3:0] StPre   = 4'd12;
  localparam logic [3:0] StPutW  = 4'd13;
  localparam logic [3:0] StMedW  = 4'd14;

  logic signed [LagW-1:0] ring_mem [WindowDepth];
  logic signed [LagW-1:0] sort_mem [WindowDepth];

  logic [3:0]             st_q;
  logic [FW-1:0]          fill_q;
  logic [AW-1:0]          head_q;
  logic [FW-1:0]          p_q;
  logic signed [LagW-1:0] old_q, rd_q, ring_rd_q;
  rswm_item_t             it_q;
  logic [LagW-1:0]        mean_q, med_q;
  logic [OutW-1:0]        out_q;
  logic                   out_full_q, div_done, start, sw_en;
  logic [LagW-1:0]        quo;
  logic [AW-1:0]          sw_addr, sr_addr;
  logic signed [LagW-1:0] sw_data;
  logic [FW-1:0]          half;

  assign q_ready_o = (st_q == StIdle);
  assign start     = q_valid_i && q_ready_o;
  assign half      = fill_q >> 1;

  rswm_div u_div (
    .clk_i, .rst_ni,
    .start_i (start),
    .num_i   (q_item_i.sum),
    .den_i   (q_item_i.count),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Sorted memory read address follows the scan pointer.
  always_comb begin
    sr_addr = AW'(p_q);
    sw_en   = 1'b0;
    sw_addr = AW'(p_q);
    sw_data = rd_q;
    case (st_q)
      // Read the top entry ahead of an insertion scan.
      StRdOld: sr_addr = AW'(fill_q - 1'b1);
      StRem: begin
        // Scan for the oldest value; the next entry is read ahead.
        sr_addr = AW'(p_q + 1'b1);
      end
      StShift: begin
        // Shift the upper entries one place down over the removed value.
        sr_addr = AW'(p_q + 2'd2);
        sw_en   = (p_q + 1'b1 < fill_q);
        sw_addr = AW'(p_q);
        sw_data = rd_q;
      end
      StTrim, StPre: sr_addr = AW'(p_q - 1'b1);
      StIns: begin
        // Shift one place up while scanning from the top.
        sr_addr = AW'(p_q - 2'd2);
        sw_en   = (p_q != '0) && (rd_q > it_q.lag);
        sw_addr = AW'(p_q);
        sw_data = rd_q;
      end
      StPut: begin
        sw_en   = 1'b1;
        sw_addr = AW'(p_q);
        sw_data = it_q.lag;
      end
      StMed:   sr_addr = AW'(half);
      default: sr_addr = AW'(p_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q      <= sort_mem[sr_addr];
    ring_rd_q <= ring_mem[head_q];
    if (sw_en) sort_mem[sw_addr] <= sw_data;
    if (st_q == StPut) ring_mem[head_q] <= it_q.lag;
  end

  // Sequencer: if full, remove the oldest, insert the new value, read median.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      fill_q     <= '0;
      head_q     <= '0;
      p_q        <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (out_full_q && out_ready_i) out_full_q <= 1'b0;
      case (st_q)
        StIdle: if (start) begin
          st_q <= StRdW;
        end
        StRdW: begin
          st_q <= StRdOld;
        end
        StRdOld: begin
          old_q <= ring_rd_q;
          if (fill_q == FW'(WindowDepth)) begin
            p_q  <= '0;
            st_q <= StFind;
          end else begin
            p_q  <= fill_q;
            st_q <= StIns;
          end
        end
        StFind: begin
          // The read at p_q is registered; the compare follows in StRem.
          st_q <= StRem;
          p_q  <= '0;
        end
        StRem: begin
          if (rd_q == old_q || p_q + 1'b1 >= fill_q) begin
            // Found: walk the tail down over it.
            st_q <= StShift;
          end else begin
            p_q <= p_q + 1'b1;
          end
        end
        StShift: begin
          if (p_q + 1'b1 >= fill_q) begin
            fill_q <= fill_q - 1'b1;
            p_q    <= fill_q - 1'b1;
            st_q   <= StTrim;
          end else begin
            p_q <= p_q + 1'b1;
          end
        end
        StTrim: begin
          st_q <= StPre;
        end
        StPre: begin
          st_q <= StIns;
        end
        StIns: begin
          if (p_q == '0 || !(rd_q > it_q.lag)) begin
            st_q <= StPut;
          end else begin
            p_q <= p_q - 1'b1;
          end
        end
        StPut: begin
          fill_q <= fill_q + 1'b1;
          head_q <= (head_q == AW'(WindowDepth - 1)) ? '0 : head_q + 1'b1;
          st_q   <= StPutW;
        end
        StPutW: st_q <= StMed;
        StMed:  st_q <= StMedW;
        StMedW: begin
          med_q <= rd_q;
          st_q  <= StWait;
        end
        StWait: if (div_done) begin
          mean_q <= quo;
          st_q   <= StOut;
        end
        StOut: if (!out_full_q) begin
          out_full_q <= 1'b1;
          st_q       <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Item capture and the output register that holds a waiting result.
  always_ff @(posedge clk_i) begin
    if (start) it_q <= q_item_i;
    if (st_q == StOut && !out_full_q) begin
      out_q <= {med_q, mean_q, it_q.hi, it_q.lo, it_q.count};
    end
  end

  assign out_valid_o = out_full_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/running_stats_window_median_core.sv
// A result follows each accepted beat once the one-bit-a-cycle mean divider and
// the window scans are done; with a full window both the removal and insertion
// scans run, each over up to WINDOW_DEPTH entries. The back part takes a sample
// only when idle; the front part holds one more, and output stalls hold both.
// Reset is asynchronous, active low; totals and window fill clear at once,
// window memories need no clearing pass.
module running_stats_window_median_core import rswm_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [31:0]     s_axis_tdata,   // lag_ms[31:0]
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [167:0]    m_axis_tdata    // sample_total, lag_min, lag_max,
                                          // lag_mean, lag_median
);

  logic       q_valid, q_ready;
  rswm_item_t q_item;

  rswm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  rswm_back #(.WindowDepth(WINDOW_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: hdl/rswm_checker.sv
// Port checker for the running statistics core.
// Depends on the top level's ports only; bound to it below.
module rswm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata
);

  // A waiting result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every result reports at least one sample.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:0] != 40'd0)
    else $error("result with zero count");

  // Minimum never exceeds maximum.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[71:40]) <= $signed(m_axis_tdata[103:72]))
    else $error("minimum above maximum");

  // Ready drops right after a beat is taken.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken too early");

endmodule

bind running_stats_window_median_core rswm_checker u_chk (.*);

FILE: tb/tb_running_stats_window_median_core.sv
// Testbench for running_stats_window_median_core: random and directed latency samples,
// with checks of count, min, max, mean and the window median against a predictor.
// Depends on rswm_pkg and the core RTL.
`timescale 1ns / 1ps

class lag_stats_board;
  logic [39:0] sample_cnt;
  logic signed [31:0] lo_seen, hi_seen;
  logic signed [63:0] sum_acc;
  logic signed [31:0] ring_q[$];
  logic signed [31:0] sorted_q[$];
  logic [167:0] pending_q[$];
  int errors;

  function new();
    sample_cnt = 0; lo_seen = 0; hi_seen = 0; sum_acc = 0; errors = 0;
  endfunction

  // Work out the result beat caused by one accepted sample.
  function void note_sample(logic signed [31:0] x);
    logic first;
    logic signed [64:0] wide;
    logic signed [63:0] q;
    logic signed [31:0] old, mean;
    int p;
    first = (sample_cnt == 0);
    if (sample_cnt != 40'hFF_FFFF_FFFF) sample_cnt++;
    if (first || x < lo_seen) lo_seen = x;
    if (first || x > hi_seen) hi_seen = x;
    wide = 65'(sum_acc) + 65'(x);
    if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) sum_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (wide < -65'sh0_8000_0000_0000_0000) sum_acc = 64'sh8000_0000_0000_0000;
    else sum_acc = wide[63:0];
    // Full window: the oldest sample leaves first.
    if (ring_q.size() >= 256) begin
      old = ring_q[0];
      ring_q.delete(0);
      p = 0;
      while (p < sorted_q.size() && sorted_q[p] != old) p++;
      sorted_q.delete(p);
    end
    p = 0;
    while (p < sorted_q.size() && sorted_q[p] <= x) p++;
    sorted_q.insert(p, x);
    ring_q.insert(ring_q.size(), x);
    q = sum_acc / $signed({24'd0, sample_cnt});
    if (q > 64'sh7FFF_FFFF) mean = 32'sh7FFF_FFFF;
    else if (q < -64'sh8000_0000) mean = 32'sh8000_0000;
    else mean = q[31:0];
    pending_q.insert(pending_q.size(),
                     {sorted_q[sorted_q.size() / 2], mean, hi_seen, lo_seen, sample_cnt});
  endfunction

  function void check_result(logic [167:0] got);
    logic [167:0] want;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = pending_q[0];
    pending_q.delete(0);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: total exp %0d got %0d, min exp %0d got %0d, ",
                  "max exp %0d got %0d, mean exp %0d got %0d, median exp %0d got %0d"},
                 want[39:0], got[39:0], $signed(want[71:40]), $signed(got[71:40]),
                 $signed(want[103:72]), $signed(got[103:72]),
                 $signed(want[135:104]), $signed(got[135:104]),
                 $signed(want[167:136]), $signed(got[167:136]));
    end
  endfunction
endclass

module tb_running_stats_window_median_core;
  import rswm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // lag_ms[31:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;       // sample_total, lag_min, lag_max, lag_mean, lag_median

  lag_stats_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  running_stats_window_median_core dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // Cycle limit: leaves room for each sample's window scans plus gaps and stalls.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 20_000_000) begin
      $display("tb_running_stats_window_median_core: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, sample at the rising edge.
  always @(posedge clk_i)
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);

  always @(negedge clk_i)
    m_axis_tready <= rst_ni && ($urandom_range(99) >= stall_pct);

  // Drive one sample beat, with random idle cycles ahead of it.
  task automatic send_lag(logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_sample(v);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_lag();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(200);
      2: return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                       : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: first sample, extremes, duplicates, sign changes.
    send_lag(32'd5);
    send_lag(32'h8000_0000);
    send_lag(32'h7FFF_FFFF);
    send_lag(32'd0);
    send_lag(32'hFFFF_FFFF);
    send_lag(32'd5);
    send_lag(32'd5);
    send_lag(32'h7FFF_FFFF);
    send_lag(32'h8000_0000);
    send_lag(32'd1);
    // Random phases; the window fills and wraps with repeated values.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 19) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 79 : 19) : 0;
      for (int k = 0; k < 410; k++) send_lag(rand_lag());
    end
    s_axis_tvalid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("tb_running_stats_window_median_core: done, clean");
    else
      $display("tb_running_stats_window_median_core: done, errors");
    $finish;
  end
endmodule
